### rtl/core/ibs_pkg.sv
// Shared types and constants for the in-place 3x3 box smoothing core.
// No dependencies; used by ibs_cell, ibs_avg and inplace_box_smooth_3x3_core.
package ibs_pkg;

  localparam int SAMPLE_W = 16;
  localparam int SUM_W    = 20;
  localparam int PROD_W   = 34;
  localparam int FRAC_W   = 16;
  localparam int TAP_N    = 9;

  // 1/9 in Q0.16
  localparam logic signed [13:0] NINTH_Q16 = 14'sd7282;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef enum logic {
    MODE_SAMPLE = 1'b0,
    MODE_DRAIN  = 1'b1
  } mode_t;

endpackage

### rtl/core/ibs_cell.sv
// One cell of the sample line: holds one Q8.8 sample, takes its neighbor's on shift.
// Depends on ibs_pkg.
module ibs_cell (
  input  logic            clk,
  input  logic            shift_en,
  input  ibs_pkg::sample_t d,
  output ibs_pkg::sample_t q
);

  ibs_pkg::sample_t data_r;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      data_r <= d;
    end
  end

  assign q = data_r;

endmodule

### rtl/core/ibs_avg.sv
// 3x3 mean: sum of nine Q8.8 taps, times 1/9 in Q0.16, floor shift by 16.
// Depends on ibs_pkg.
module ibs_avg (
  input  ibs_pkg::sample_t taps [ibs_pkg::TAP_N],
  output ibs_pkg::sample_t avg
);

  logic signed [ibs_pkg::SUM_W-1:0]  ext [ibs_pkg::TAP_N];
  logic signed [ibs_pkg::SUM_W-1:0]  sum_a, sum_b, sum;
  logic signed [ibs_pkg::PROD_W-1:0] sum_x, coef_x, prod;

  always_comb begin
    for (int i = 0; i < ibs_pkg::TAP_N; i++) begin
      ext[i] = ibs_pkg::SUM_W'(taps[i]);
    end
  end

  assign sum_a  = (ext[0] + ext[1]) + (ext[2] + ext[3]);
  assign sum_b  = (ext[4] + ext[5]) + (ext[6] + ext[7]);
  assign sum    = sum_a + sum_b + ext[8];
  assign sum_x  = ibs_pkg::PROD_W'(sum);
  assign coef_x = ibs_pkg::PROD_W'(ibs_pkg::NINTH_Q16);
  assign prod   = sum_x * coef_x;
  // arithmetic shift right = floor
  assign avg    = prod[ibs_pkg::FRAC_W +: ibs_pkg::SAMPLE_W];

endmodule

### rtl/core/inplace_box_smooth_3x3_core.sv
// Top level of the in-place 3x3 box smoothing core: cell line, counters, result register.
// Depends on ibs_pkg, ibs_cell, ibs_avg.
//
//   channel | ports                               | dir | request
//   in      | in_mode, in_sample                  | in  | one sample or drain tick
//   out     | out_row, out_col, out_value, out_last | out | one grid sample
//
// One request per cycle while in_ready is high; a result appears in the output register
// the cycle after the request that releases it, one row plus one sample behind the input.
// The line of 2*GRID_SIDE+2 cells shifts on each stored sample and each result.
// Reset clears counters and the output valid only; no clearing pass.
// in_ready drops only while a result sits unaccepted with out_ready low.
module inplace_box_smooth_3x3_core #(
  parameter int GRID_SIDE   = 65,
  parameter int EDGE_MARGIN = 2
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_mode,
  input  logic signed [15:0]            in_sample,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [$clog2(GRID_SIDE)-1:0]  out_row,
  output logic [$clog2(GRID_SIDE)-1:0]  out_col,
  output logic signed [15:0]            out_value,
  output logic                          out_last
);

  localparam int IDX_W  = $clog2(GRID_SIDE);
  localparam int PEND_W = $clog2(GRID_SIDE + 3);
  localparam int CELLS  = 2 * GRID_SIDE + 2;
  localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(GRID_SIDE - 1);
  localparam logic [IDX_W-1:0]  LO_IDX   = IDX_W'(EDGE_MARGIN);
  localparam logic [IDX_W-1:0]  HI_IDX   = IDX_W'(GRID_SIDE - 1 - EDGE_MARGIN);
  localparam logic [PEND_W-1:0] MID_LAG  = PEND_W'(GRID_SIDE + 1);
  localparam logic [PEND_W-1:0] FULL_LAG = PEND_W'(GRID_SIDE + 2);

  logic [IDX_W-1:0]  in_row_r, in_row_nxt, in_col_r, in_col_nxt;
  logic              in_full_r, in_full_nxt;
  logic [PEND_W-1:0] pend_r, pend_nxt;
  logic [IDX_W-1:0]  o_row_r, o_row_nxt, o_col_r, o_col_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]  out_row_r, out_row_nxt, out_col_r, out_col_nxt;
  ibs_pkg::sample_t  out_value_r, out_value_nxt;
  logic              out_last_r, out_last_nxt;

  logic              in_fire, wrote, in_end, full_now, emit, out_end, shift_en, interior;
  logic [PEND_W-1:0] pend_now;
  ibs_pkg::sample_t  avg, val;
  ibs_pkg::sample_t  cell_d [CELLS];
  ibs_pkg::sample_t  cell_q [CELLS];
  ibs_pkg::sample_t  taps   [ibs_pkg::TAP_N];

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign wrote    = in_fire && (in_mode == ibs_pkg::MODE_SAMPLE) && !in_full_r;
  assign in_end   = (in_row_r == LAST_IDX) && (in_col_r == LAST_IDX);
  assign full_now = in_full_r || (wrote && in_end);
  assign pend_now = pend_r + PEND_W'(wrote);
  assign emit     = in_fire && (pend_now != '0) && (full_now || (pend_now >= FULL_LAG));
  assign out_end  = (o_row_r == LAST_IDX) && (o_col_r == LAST_IDX);
  assign shift_en = wrote || emit;
  assign interior = emit && (o_row_r >= LO_IDX) && (o_row_r < HI_IDX) &&
                    (o_col_r >= LO_IDX) && (o_col_r < HI_IDX);

  // pre-shift taps around result p: incoming is p+N+1, cell k holds p+N-k
  assign taps[0] = in_sample;
  assign taps[1] = cell_q[0];
  assign taps[2] = cell_q[1];
  assign taps[3] = cell_q[GRID_SIDE - 1];
  assign taps[4] = cell_q[GRID_SIDE];
  assign taps[5] = cell_q[GRID_SIDE + 1];
  assign taps[6] = cell_q[2 * GRID_SIDE - 1];
  assign taps[7] = cell_q[2 * GRID_SIDE];
  assign taps[8] = cell_q[2 * GRID_SIDE + 1];

  ibs_avg u_avg (
    .taps (taps),
    .avg  (avg)
  );

  assign val = interior ? avg : cell_q[GRID_SIDE];

  always_comb begin
    cell_d[0] = in_sample;
    for (int k = 1; k < CELLS; k++) begin
      cell_d[k] = cell_q[k-1];
    end
    // in-place write-back of result p
    cell_d[GRID_SIDE + 1] = val;
  end

  for (genvar k = 0; k < CELLS; k++) begin : g_cell
    ibs_cell u_cell (
      .clk      (clk),
      .shift_en (shift_en),
      .d        (cell_d[k]),
      .q        (cell_q[k])
    );
  end

  always_comb begin
    in_row_nxt    = in_row_r;
    in_col_nxt    = in_col_r;
    in_full_nxt   = full_now;
    pend_nxt      = pend_now - PEND_W'(emit);
    o_row_nxt     = o_row_r;
    o_col_nxt     = o_col_r;
    out_valid_nxt = out_valid_r;
    out_row_nxt   = out_row_r;
    out_col_nxt   = out_col_r;
    out_value_nxt = out_value_r;
    out_last_nxt  = out_last_r;

    if (wrote) begin
      if (in_col_r == LAST_IDX) begin
        in_col_nxt = '0;
        in_row_nxt = in_end ? '0 : in_row_r + 1'b1;
      end else begin
        in_col_nxt = in_col_r + 1'b1;
      end
    end

    if (emit) begin
      if (o_col_r == LAST_IDX) begin
        o_col_nxt = '0;
        o_row_nxt = o_row_r + 1'b1;
      end else begin
        o_col_nxt = o_col_r + 1'b1;
      end
      out_valid_nxt = 1'b1;
      out_row_nxt   = o_row_r;
      out_col_nxt   = o_col_r;
      out_value_nxt = val;
      out_last_nxt  = out_end;
      if (out_end) begin
        in_row_nxt  = '0;
        in_col_nxt  = '0;
        in_full_nxt = 1'b0;
        pend_nxt    = '0;
        o_row_nxt   = '0;
        o_col_nxt   = '0;
      end
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_row_r    <= '0;
      in_col_r    <= '0;
      in_full_r   <= 1'b0;
      pend_r      <= '0;
      o_row_r     <= '0;
      o_col_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      in_row_r    <= in_row_nxt;
      in_col_r    <= in_col_nxt;
      in_full_r   <= in_full_nxt;
      pend_r      <= pend_nxt;
      o_row_r     <= o_row_nxt;
      o_col_r     <= o_col_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_row_r   <= out_row_nxt;
    out_col_r   <= out_col_nxt;
    out_value_r <= out_value_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_row   = out_row_r;
  assign out_col   = out_col_r;
  assign out_value = out_value_r;
  assign out_last  = out_last_r;

  a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= MID_LAG)
    else $error("pending count above lag");

  a_pend_steady: assert property (@(posedge clk) disable iff (!rst_n)
    !in_full_r && (in_row_r != '0) && (in_col_r != '0) |-> pend_r == MID_LAG)
    else $error("pending count off mid-grid");

  a_grid_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    emit && out_end |=> (pend_r == '0) && !in_full_r && (in_row_r == '0) &&
                        (in_col_r == '0) && (o_row_r == '0) && (o_col_r == '0))
    else $error("counters not cleared after last result");

  a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_last_r |-> (out_row_r == LAST_IDX) && (out_col_r == LAST_IDX))
    else $error("last flag on wrong position");

  a_no_emit_idle: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> (pend_r != '0) || wrote)
    else $error("result without pending sample");

endmodule

### verif/tb_top.sv
`timescale 1ns / 100ps
// Testbench for inplace_box_smooth_3x3_core: part of a 65x65 grid streamed in raster order
// with drain requests and random stalls on both sides, every result checked against a local
// predictor. Depends on ibs_pkg and the core RTL.
module tb_top;

  localparam int GRID_SIDE      = 65;
  localparam int EDGE_MARGIN    = 2;
  localparam int IDX_W          = $clog2(GRID_SIDE);
  localparam int CELLS          = GRID_SIDE * GRID_SIDE;
  localparam int LINE_DEPTH     = 2 * GRID_SIDE + 3;
  localparam int WATCHDOG_LIMIT = 400;
  localparam int STREAM_ITEMS   = 900;
  localparam int CALM_ITEMS     = 300;

  typedef struct {
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    ibs_pkg::sample_t value;
    logic             last;
  } cell_result_t;

  class smooth_scoreboard;
    ibs_pkg::sample_t heights[LINE_DEPTH];
    int unsigned      rx_row;
    int unsigned      rx_col;
    int unsigned      tx_index;
    cell_result_t     expected_q[$];
    int               errors;
    int               requests;
    int               results;
    int               smoothed;

    function int unsigned received();
      return (rx_row >= GRID_SIDE) ? CELLS : rx_row * GRID_SIDE + rx_col;
    endfunction

    function bit stream_full();
      return received() == CELLS;
    endfunction

    function int unsigned slot(int unsigned p, int offset);
      return (int'(p % LINE_DEPTH) + LINE_DEPTH + offset) % LINE_DEPTH;
    endfunction

    function void note_request(ibs_pkg::mode_t mode, ibs_pkg::sample_t s);
      int unsigned  recv;
      int unsigned  r;
      int unsigned  c;
      longint       acc;
      cell_result_t res;
      recv = received();
      requests++;
      if (mode == ibs_pkg::MODE_SAMPLE && recv < CELLS) begin
        heights[recv % LINE_DEPTH] = s;
        rx_col++;
        if (rx_col >= GRID_SIDE) begin
          rx_col = 0;
          rx_row++;
        end
        recv++;
      end
      if (!(tx_index < recv && (recv == CELLS || recv >= tx_index + GRID_SIDE + 2)))
        return;
      r = tx_index / GRID_SIDE;
      c = tx_index % GRID_SIDE;
      if (r >= EDGE_MARGIN && r < GRID_SIDE - 1 - EDGE_MARGIN &&
          c >= EDGE_MARGIN && c < GRID_SIDE - 1 - EDGE_MARGIN) begin
        acc = 0;
        for (int dr = -1; dr <= 1; dr++)
          for (int dc = -1; dc <= 1; dc++)
            acc += heights[slot(tx_index, dr * GRID_SIDE + dc)];
        acc = acc * longint'(ibs_pkg::NINTH_Q16);
        res.value = ibs_pkg::sample_t'(acc >>> 16);
        heights[slot(tx_index, 0)] = res.value;
        smoothed++;
      end else begin
        res.value = heights[slot(tx_index, 0)];
      end
      res.row  = r[IDX_W-1:0];
      res.col  = c[IDX_W-1:0];
      res.last = (tx_index == CELLS - 1);
      expected_q.push_back(res);
      tx_index++;
      if (tx_index >= CELLS) begin
        tx_index = 0;
        rx_row   = 0;
        rx_col   = 0;
      end
    endfunction

    function void check_result(logic [IDX_W-1:0] row, logic [IDX_W-1:0] col,
                               ibs_pkg::sample_t value, logic last);
      cell_result_t exp_res;
      results++;
      if (expected_q.size() == 0) begin
        $error("unexpected result: row %0d col %0d value %0d", row, col, value);
        errors++;
        return;
      end
      exp_res = expected_q.pop_front();
      if (row !== exp_res.row) begin
        $error("row: expected %0d, actual %0d", exp_res.row, row);
        errors++;
      end
      if (col !== exp_res.col) begin
        $error("col: expected %0d, actual %0d", exp_res.col, col);
        errors++;
      end
      if (value !== exp_res.value) begin
        $error("value: expected %0d, actual %0d", exp_res.value, value);
        errors++;
      end
      if (last !== exp_res.last) begin
        $error("last: expected %0d, actual %0d", exp_res.last, last);
        errors++;
      end
    endfunction
  endclass

  logic                    clk       = 1'b0;
  logic                    rst_n     = 1'b0;
  logic                    in_valid  = 1'b0;
  logic                    in_ready;
  logic                    in_mode   = ibs_pkg::MODE_SAMPLE;
  ibs_pkg::sample_t        in_sample = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [IDX_W-1:0]        out_row;
  logic [IDX_W-1:0]        out_col;
  ibs_pkg::sample_t        out_value;
  logic                    out_last;

  smooth_scoreboard        sb = new;
  bit                      calm = 1'b0;
  int                      stall_left = 0;
  int                      quiet_cycles = 0;

  always #4 clk = ~clk;

  inplace_box_smooth_3x3_core #(
    .GRID_SIDE   (GRID_SIDE),
    .EDGE_MARGIN (EDGE_MARGIN)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_mode   (in_mode),
    .in_sample (in_sample),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_row   (out_row),
    .out_col   (out_col),
    .out_value (out_value),
    .out_last  (out_last)
  );

  task automatic send_request(ibs_pkg::mode_t mode, ibs_pkg::sample_t s);
    in_valid  <= 1'b1;
    in_mode   <= mode;
    in_sample <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request(mode, s);
  endtask

  task automatic maybe_pause();
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  // flavors: full range, near max, near min, small around zero
  function automatic ibs_pkg::sample_t random_height(int unsigned flavor);
    case (flavor)
      0: return ibs_pkg::sample_t'($urandom);
      1: return 16'sh7FFF - ibs_pkg::sample_t'($urandom_range(0, 15));
      2: return 16'sh8000 + ibs_pkg::sample_t'($urandom_range(0, 15));
      default: return ibs_pkg::sample_t'($urandom_range(0, 63)) - 16'sd32;
    endcase
  endfunction

  task automatic stream_grid(int limit);
    int unsigned flavor;
    flavor = 0;
    while (!sb.stream_full() && sb.requests < limit) begin
      if (sb.rx_col == 0) flavor = $urandom_range(0, 3);
      if ($urandom_range(0, 19) == 0)
        send_request(ibs_pkg::MODE_DRAIN, ibs_pkg::sample_t'($urandom));
      else send_request(ibs_pkg::MODE_SAMPLE, random_height(flavor));
      maybe_pause();
    end
    // grid complete: samples here are ignored and act as drains
    while (sb.stream_full() && sb.requests < limit) begin
      send_request(($urandom_range(0, 2) == 0) ? ibs_pkg::MODE_SAMPLE : ibs_pkg::MODE_DRAIN,
                   ibs_pkg::sample_t'($urandom));
      maybe_pause();
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result(out_row, out_col, out_value, out_last);
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 4);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    send_request(ibs_pkg::MODE_DRAIN, 16'sh7FFF);
    send_request(ibs_pkg::MODE_SAMPLE, 16'sh7FFF);
    send_request(ibs_pkg::MODE_SAMPLE, 16'sh8000);
    send_request(ibs_pkg::MODE_SAMPLE, 16'sh0000);
    send_request(ibs_pkg::MODE_SAMPLE, 16'shFFFF);
    send_request(ibs_pkg::MODE_SAMPLE, 16'sh0001);
    send_request(ibs_pkg::MODE_DRAIN, 16'sh8000);
    send_request(ibs_pkg::MODE_SAMPLE, 16'sh5555);
    send_request(ibs_pkg::MODE_SAMPLE, 16'shAAAA);
    maybe_pause();
    send_request(ibs_pkg::MODE_DRAIN, 16'sh5555);
    send_request(ibs_pkg::MODE_SAMPLE, 16'sh7FFE);
    send_request(ibs_pkg::MODE_SAMPLE, 16'sh8001);

    stream_grid(STREAM_ITEMS);

    calm = 1'b1;
    repeat (CALM_ITEMS) send_request(ibs_pkg::MODE_SAMPLE, random_height($urandom_range(0, 3)));
    in_valid <= 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Streamed %0d requests with drain ticks and stalls, reaching row %0d of the grid.",
             sb.requests, sb.rx_row);
    $display("Checked %0d results, %0d of them smoothed interior cells.",
             sb.results, sb.smoothed);
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
